>>> design/aca_pkg.sv
`default_nettype none
package aca_pkg;

	localparam int NODE_W = 10;
	localparam int SYM_W = 5;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_BUILD = 2'd1;
	localparam logic [1:0] OP_MATCH = 2'd2;

	localparam logic [1:0] ST_OK = 2'd0;
	localparam logic [1:0] ST_FULL = 2'd1;
	localparam logic [1:0] ST_AFTER_BUILD = 2'd2;
	localparam logic [1:0] ST_BEFORE_BUILD = 2'd3;

	typedef struct packed {
		logic [1:0] opcode;
		logic [SYM_W-1:0] symbol;
		logic mark;
	} req_t;

	typedef struct packed {
		logic [NODE_W-1:0] node;
		logic [NODE_W-1:0] fail_node;
		logic [1:0] status;
	} rsp_t;

	// decoded word, symbol already reduced into the alphabet
	typedef struct packed {
		logic [1:0] opcode;
		logic [SYM_W-1:0] symbol;
		logic mark;
	} cmd_t;

endpackage
`default_nettype wire

>>> design/aca_front.sv
`default_nettype none
module aca_front #(
	parameter int ALPHABET = 26
) (
	input  aca_pkg::req_t req,
	input  wire           req_valid,
	input  wire           fifo_full,
	input  wire           clearing,
	output logic          req_stall,
	output logic          push,
	output aca_pkg::cmd_t cmd
);
	import aca_pkg::*;

	logic [SYM_W-1:0] sym_mod;

	// symbol reduced modulo the alphabet by a constant table
	always_comb begin
		sym_mod = '0;
		for (int i = 0; i < 32; i++) begin
			if (req.symbol == SYM_W'(i)) begin
				sym_mod = SYM_W'(i % ALPHABET);
			end
		end
	end

	assign req_stall = fifo_full | clearing;
	assign push = req_valid & ~req_stall;
	assign cmd = '{opcode: req.opcode, symbol: sym_mod, mark: req.mark};

endmodule
`default_nettype wire

>>> design/aca_cmd_fifo.sv
`default_nettype none
module aca_cmd_fifo (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           push,
	input  aca_pkg::cmd_t push_data,
	input  wire           pop,
	output logic          full,
	output logic          not_empty,
	output aca_pkg::cmd_t head
);
	import aca_pkg::*;

	cmd_t       mem_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_q] <= push_data;
		end
	end

	assign full = cnt_q[1];
	assign not_empty = cnt_q != 2'd0;
	assign head = mem_q[rd_q];

endmodule
`default_nettype wire

>>> design/aca_engine.sv
`default_nettype none
module aca_engine #(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET = 26
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           cmd_valid,
	input  aca_pkg::cmd_t cmd,
	output logic          pop,
	output logic          clearing,
	output logic          rsp_valid,
	input  wire           rsp_stall,
	output aca_pkg::rsp_t rsp
);
	import aca_pkg::*;

	localparam int NW = (MAX_NODES > 2) ? $clog2(MAX_NODES) : 1;
	localparam int CW = $clog2(MAX_NODES + 1);
	localparam int SW = $clog2(ALPHABET);
	localparam int GDEPTH = MAX_NODES * ALPHABET;
	localparam int GW = $clog2(GDEPTH);

	localparam logic [3:0] S_CLR = 4'd0;
	localparam logic [3:0] S_IDLE = 4'd1;
	localparam logic [3:0] S_INS = 4'd2;
	localparam logic [3:0] S_MT1 = 4'd3;
	localparam logic [3:0] S_MT2 = 4'd4;
	localparam logic [3:0] S_B0RD = 4'd5;
	localparam logic [3:0] S_B0EV = 4'd6;
	localparam logic [3:0] S_BQ = 4'd7;
	localparam logic [3:0] S_BV = 4'd8;
	localparam logic [3:0] S_BF = 4'd9;
	localparam logic [3:0] S_BC = 4'd10;
	localparam logic [3:0] S_BCH = 4'd11;
	localparam logic [3:0] S_BVIA = 4'd12;
	localparam logic [3:0] S_DONE = 4'd13;

	logic [3:0]    state_q;
	logic [GW-1:0] clr_q;
	cmd_t          cmd_q;
	logic [CW-1:0] count_q;
	logic [NW-1:0] cursor_q;
	logic [NW-1:0] text_q;
	logic          built_q;
	logic [CW-1:0] head_q;
	logic [CW-1:0] tail_q;
	logic [SW-1:0] sym_q;
	logic [NW-1:0] v_q;
	logic [NW-1:0] fv_q;
	logic [NW-1:0] child_q;
	rsp_t          res_q;
	logic          out_valid_q;
	rsp_t          out_q;

	logic [NW-1:0] gmem [GDEPTH];
	logic [NW-1:0] fmem [MAX_NODES];
	logic [NW-1:0] qmem [MAX_NODES];

	logic [NW-1:0] g_node;
	logic [SW-1:0] g_sym;
	logic [GW-1:0] g_addr;
	logic          g_we;
	logic [NW-1:0] g_wdata;
	logic [NW-1:0] g_rdata;
	logic [NW-1:0] f_addr;
	logic          f_we;
	logic [NW-1:0] f_rdata;
	logic          q_we;
	logic [NW-1:0] q_wdata;
	logic [NW-1:0] q_rdata;
	logic [SW-1:0] cmd_sym;
	logic [SW-1:0] hd_sym;
	logic          room;
	logic          last_sym;

	function automatic rsp_t pack(input logic [NW-1:0] n, input logic [NW-1:0] f,
			input logic [1:0] s);
		rsp_t r;
		r.node = NODE_W'(n);
		r.fail_node = NODE_W'(f);
		r.status = s;
		return r;
	endfunction

	assign cmd_sym = SW'(cmd_q.symbol);
	assign hd_sym = SW'(cmd.symbol);
	assign room = count_q < CW'(MAX_NODES);
	assign last_sym = sym_q == SW'(ALPHABET - 1);
	assign pop = (state_q == S_IDLE) && cmd_valid;
	assign clearing = state_q == S_CLR;
	assign rsp_valid = out_valid_q;
	assign rsp = out_q;

	always_comb begin
		g_node = v_q;
		g_sym = sym_q;
		case (state_q)
			S_IDLE: begin
				g_sym = hd_sym;
				if (cmd.opcode == OP_MATCH) begin
					g_node = cmd.mark ? '0 : text_q;
				end else begin
					g_node = cursor_q;
				end
			end
			S_INS: begin
				g_node = cursor_q;
				g_sym = cmd_sym;
			end
			S_B0RD: g_node = '0;
			S_BCH: g_node = fv_q;
			default: g_node = v_q;
		endcase
	end

	assign g_addr = (state_q == S_CLR) ? clr_q
		: GW'(GW'(g_node) * GW'(ALPHABET) + GW'(g_sym));
	assign g_we = (state_q == S_CLR)
		|| ((state_q == S_INS) && (g_rdata == '0) && room && !built_q)
		|| ((state_q == S_BVIA) && (child_q == '0));
	assign g_wdata = (state_q == S_CLR) ? '0
		: (state_q == S_INS) ? NW'(count_q) : g_rdata;

	always_comb begin
		case (state_q)
			S_CLR: f_addr = clr_q[NW-1:0];
			S_MT1: f_addr = g_rdata;
			S_BV: f_addr = q_rdata;
			default: f_addr = child_q;
		endcase
	end
	assign f_we = ((state_q == S_CLR) && (GW'(clr_q) < GW'(MAX_NODES)))
		|| ((state_q == S_BVIA) && (child_q != '0));

	assign q_we = ((state_q == S_B0EV) && (g_rdata != '0))
		|| ((state_q == S_BVIA) && (child_q != '0));
	assign q_wdata = (state_q == S_B0EV) ? g_rdata : child_q;

	always_ff @(posedge clk) begin
		if (g_we) begin
			gmem[g_addr] <= g_wdata;
		end
		g_rdata <= gmem[g_addr];
	end

	always_ff @(posedge clk) begin
		if (f_we) begin
			fmem[f_addr] <= (state_q == S_CLR) ? '0 : g_rdata;
		end
		f_rdata <= fmem[f_addr];
	end

	always_ff @(posedge clk) begin
		if (q_we) begin
			qmem[tail_q[NW-1:0]] <= q_wdata;
		end
		q_rdata <= qmem[head_q[NW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLR;
			clr_q <= '0;
			count_q <= CW'(1);
			cursor_q <= '0;
			text_q <= '0;
			built_q <= 1'b0;
			head_q <= '0;
			tail_q <= '0;
			sym_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			case (state_q)
				S_CLR: begin
					clr_q <= clr_q + GW'(1);
					if (clr_q == GW'(GDEPTH - 1)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (cmd_valid) begin
						case (cmd.opcode)
							OP_INSERT: begin
								if (built_q) begin
									res_q <= pack(cursor_q, '0, ST_AFTER_BUILD);
									state_q <= S_DONE;
								end else begin
									state_q <= S_INS;
								end
							end
							OP_BUILD: begin
								res_q <= pack('0, '0, ST_OK);
								if (built_q) begin
									state_q <= S_DONE;
								end else begin
									sym_q <= '0;
									head_q <= '0;
									tail_q <= '0;
									state_q <= S_B0RD;
								end
							end
							OP_MATCH: begin
								if (!built_q) begin
									res_q <= pack(text_q, '0, ST_BEFORE_BUILD);
									state_q <= S_DONE;
								end else begin
									state_q <= S_MT1;
								end
							end
							default: begin
								res_q <= pack('0, '0, ST_OK);
								state_q <= S_DONE;
							end
						endcase
					end
				end
				S_INS: begin
					if (g_rdata != '0) begin
						cursor_q <= cmd_q.mark ? '0 : g_rdata;
						res_q <= pack(g_rdata, '0, ST_OK);
					end else if (room) begin
						count_q <= count_q + CW'(1);
						cursor_q <= cmd_q.mark ? '0 : NW'(count_q);
						res_q <= pack(NW'(count_q), '0, ST_OK);
					end else begin
						cursor_q <= cmd_q.mark ? '0 : cursor_q;
						res_q <= pack(cursor_q, '0, ST_FULL);
					end
					state_q <= S_DONE;
				end
				S_MT1: begin
					text_q <= g_rdata;
					state_q <= S_MT2;
				end
				S_MT2: begin
					res_q <= pack(text_q, f_rdata, ST_OK);
					state_q <= S_DONE;
				end
				S_B0RD: state_q <= S_B0EV;
				S_B0EV: begin
					if (g_rdata != '0) begin
						tail_q <= tail_q + CW'(1);
					end
					sym_q <= last_sym ? '0 : sym_q + SW'(1);
					state_q <= last_sym ? S_BQ : S_B0RD;
				end
				S_BQ: begin
					if (head_q == tail_q) begin
						built_q <= 1'b1;
						text_q <= '0;
						state_q <= S_DONE;
					end else begin
						head_q <= head_q + CW'(1);
						state_q <= S_BV;
					end
				end
				S_BV: begin
					v_q <= q_rdata;
					state_q <= S_BF;
				end
				S_BF: begin
					fv_q <= f_rdata;
					sym_q <= '0;
					state_q <= S_BC;
				end
				S_BC: state_q <= S_BCH;
				S_BCH: begin
					child_q <= g_rdata;
					state_q <= S_BVIA;
				end
				S_BVIA: begin
					if (child_q != '0) begin
						tail_q <= tail_q + CW'(1);
					end
					sym_q <= last_sym ? '0 : sym_q + SW'(1);
					state_q <= last_sym ? S_BQ : S_BC;
				end
				S_DONE: begin
					if (!out_valid_q || !rsp_stall) begin
						out_q <= res_q;
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
			if ((state_q == S_DONE) && (!out_valid_q || !rsp_stall)) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !rsp_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			cmd_q <= cmd;
		end
	end

endmodule
`default_nettype wire

>>> design/aho_corasick_automaton.sv
// channel   signals                     word
// req       req_valid, req_stall        req (opcode, symbol, mark)
// rsp       rsp_valid, rsp_stall        rsp (node, fail_node, status)
//
// insert and match each wait on the registered goto ram read; match also reads the fail ram
// build scans the root's children first, then each queued trie node in breadth-first order
// after reset the goto ram is swept while req is stalled
// a two-word command queue keeps req open while a result waits on rsp_stall
`default_nettype none
module aho_corasick_automaton #(
	parameter int MAX_NODES = 1024,
	parameter int ALPHABET = 26
) (
	input  wire           clk,
	input  wire           arst_n,
	input  wire           req_valid,
	output logic          req_stall,
	input  aca_pkg::req_t req,
	output logic          rsp_valid,
	input  wire           rsp_stall,
	output aca_pkg::rsp_t rsp
);
	import aca_pkg::*;

	logic push;
	cmd_t push_cmd;
	logic full;
	logic not_empty;
	cmd_t head;
	logic pop;
	logic clearing;

	aca_front #(.ALPHABET(ALPHABET)) u_front (
		.req(req),
		.req_valid(req_valid),
		.fifo_full(full),
		.clearing(clearing),
		.req_stall(req_stall),
		.push(push),
		.cmd(push_cmd)
	);

	aca_cmd_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_cmd),
		.pop(pop),
		.full(full),
		.not_empty(not_empty),
		.head(head)
	);

	aca_engine #(.MAX_NODES(MAX_NODES), .ALPHABET(ALPHABET)) u_engine (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(not_empty),
		.cmd(head),
		.pop(pop),
		.clearing(clearing),
		.rsp_valid(rsp_valid),
		.rsp_stall(rsp_stall),
		.rsp(rsp)
	);

endmodule
`default_nettype wire

>>> design/aca_checker.sv
`default_nettype none
module aca_checker (
	input wire           clk,
	input wire           arst_n,
	input wire           req_valid,
	input wire           req_stall,
	input aca_pkg::req_t req,
	input wire           rsp_valid,
	input wire           rsp_stall,
	input aca_pkg::rsp_t rsp
);
	import aca_pkg::*;

	a_req_hold: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_stall |=> req_valid && $stable(req))
		else $error("req word changed under stall");

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("rsp word changed under stall");

	a_err_no_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status != ST_OK |-> rsp.fail_node == '0)
		else $error("error word carries a failure link");

	a_root_fail: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.node == '0 |-> rsp.fail_node == '0)
		else $error("root reported with nonzero failure link");

	a_reset_quiet: assert property (@(posedge clk)
		!arst_n |-> !rsp_valid)
		else $error("rsp valid during reset");

endmodule

bind aho_corasick_automaton aca_checker u_chk (.*);
`default_nettype wire
